FILE: src/bba_pkg.sv
// Shared constants, types and search functions for the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int POOL_WORDS  = 32;
  localparam int WORD_BITS   = 32;
  localparam int POOL_BLOCKS = POOL_WORDS * WORD_BITS;
  localparam int ADDR_W      = $clog2(POOL_WORDS);
  localparam int POS_W       = $clog2(WORD_BITS);
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 11;
  localparam int ACT_W       = 2;

  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COUNT = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [POOL_WORDS-1:0] flags_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // lowest index of a clear flag
  function automatic addr_t first_clear_low(input flags_t v);
    addr_t idx;
    idx = '0;
    for (int i = POOL_WORDS - 1; i >= 0; i--) begin
      if (!v[i]) idx = addr_t'(i);
    end
    return idx;
  endfunction

  // position, counted from the top bit down, of the first clear bit
  function automatic pos_t first_clear_high(input word_t w);
    pos_t pos;
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!w[i]) pos = pos_t'(WORD_BITS - 1 - i);
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

FILE: src/bba_ram.sv
// Single-port synchronous RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: src/bitmap_block_allocator_unit.sv
// Top level of the first-fit bitmap block allocator.
//
// For each request word, the accept edge reads the bitmap word from the
// single-port RAM (for allocate, the word is picked from a register of
// per-word full flags), and a later edge modifies it, writes it back and
// loads the result register. No new request is accepted before that
// write-back, as there is a single RAM port. A new request is accepted
// while a result waits in the output register; it then holds, with its
// word read, until the result is taken. All blocks are free right after
// reset; there is no clearing pass, a per-word valid flag makes unwritten words read as zero.
`default_nettype none
module bitmap_block_allocator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // [1:0] action, [11:2] block_index, [15:12] zero
  input  wire logic [bba_pkg::IN_DATA_W-1:0]  in_tdata,
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [9:0] granted_block, [10] status, [21:11] free_blocks, [23:22] zero
  output      logic [bba_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bba_pkg::*;

  logic                 busy_r;
  logic [ACT_W-1:0]     act_r;
  addr_t                addr_r;
  pos_t                 pos_r;
  logic                 rd_valid_r;
  flags_t               full_r;
  flags_t               full_nxt;
  flags_t               wvalid_r;
  cnt_t                 free_total_r;
  cnt_t                 free_total_nxt;
  logic                 out_valid_r;
  logic [BLK_W-1:0]     granted_r;
  logic                 status_r;

  logic                 in_acc;
  logic                 advance;
  logic [ACT_W-1:0]     in_action;
  logic [BLK_W-1:0]     in_index;
  addr_t                rd_addr;
  addr_t                ram_addr;
  word_t                ram_rd;
  word_t                cur_word;
  word_t                new_word;
  pos_t                 hit_pos;
  word_t                free_mask;
  logic                 wr_en;
  logic [BLK_W-1:0]     granted_nxt;
  logic                 status_nxt;

  assign in_action = in_tdata[ACT_W-1:0];
  assign in_index  = in_tdata[ACT_W+BLK_W-1:ACT_W];
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign advance   = busy_r && (!out_valid_r || out_tready);

  assign rd_addr  = (in_action == ACT_ALLOC) ? first_clear_low(full_r)
                                             : in_index[POS_W+ADDR_W-1:POS_W];
  assign ram_addr = busy_r ? addr_r : rd_addr;

  bba_ram #(
    .DEPTH (POOL_WORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .wr_en   (wr_en),
    .addr    (ram_addr),
    .wr_data (new_word),
    .rd_data (ram_rd)
  );

  assign cur_word  = rd_valid_r ? ram_rd : '0;
  assign hit_pos   = first_clear_high(cur_word);
  assign free_mask = word_t'(1) << (POS_W'(WORD_BITS - 1) - pos_r);

  always_comb begin
    new_word       = cur_word;
    wr_en          = 1'b0;
    full_nxt       = full_r;
    free_total_nxt = free_total_r;
    granted_nxt    = '0;
    status_nxt     = STATUS_DONE;
    case (act_r)
      ACT_ALLOC: begin
        if (free_total_r == '0) begin
          status_nxt = STATUS_FULL;
        end else begin
          new_word       = cur_word | (word_t'(1) << (POS_W'(WORD_BITS - 1) - hit_pos));
          wr_en          = advance;
          full_nxt[addr_r] = &new_word;
          free_total_nxt = free_total_r - cnt_t'(1);
          granted_nxt    = BLK_W'({addr_r, hit_pos});
        end
      end
      ACT_FREE: begin
        if ((cur_word & free_mask) != '0) begin
          new_word         = cur_word & ~free_mask;
          wr_en            = advance;
          full_nxt[addr_r] = 1'b0;
          free_total_nxt   = free_total_r + cnt_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      full_r       <= '0;
      wvalid_r     <= '0;
      free_total_r <= cnt_t'(POOL_BLOCKS);
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (advance) begin
        busy_r       <= 1'b0;
        full_r       <= full_nxt;
        free_total_r <= free_total_nxt;
        if (wr_en) wvalid_r[addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r      <= in_action;
      addr_r     <= rd_addr;
      pos_r      <= in_index[POS_W-1:0];
      rd_valid_r <= wvalid_r[rd_addr];
    end
    if (advance) begin
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - BLK_W - 1 - CNT_W)'(0), free_total_r, status_r, granted_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= cnt_t'(POOL_BLOCKS))
    else $error("free count beyond pool size");

  a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (&full_r) == (free_total_r == '0))
    else $error("full flags disagree with free count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && !in_tready)
    else $error("request not held after accept");

  a_full_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == STATUS_FULL |-> granted_r == '0)
    else $error("grant reported with pool full");

endmodule
`default_nettype wire
